// File: rtl/core/talu_pkg.sv
// Shared constants and types for the tagged integer ALU.
`timescale 1ns / 1ps
package talu_pkg;
    localparam int DEF_DATA_WIDTH = 64;
    localparam int FIELD_WIDTH = 64;

    localparam logic [3:0] CMD_ADD = 4'd0;
    localparam logic [3:0] CMD_SUB = 4'd1;
    localparam logic [3:0] CMD_MUL = 4'd2;
    localparam logic [3:0] CMD_DIV = 4'd3;
    localparam logic [3:0] CMD_REM = 4'd4;
    localparam logic [3:0] CMD_POW = 4'd5;
    localparam logic [3:0] CMD_MIN = 4'd6;
    localparam logic [3:0] CMD_MAX = 4'd7;

    localparam logic [1:0] ERR_DIV_ZERO = 2'd0;
    localparam logic [1:0] ERR_BAD_OP = 2'd1;

    // request from the sequencer to the serial multiplier
    typedef struct packed {
        logic start;
    } t_mul_ctl;
endpackage

// File: rtl/core/talu_mul.sv
// Bit-serial shift-and-add multiplier, product wraps to the data width.
`timescale 1ns / 1ps
module talu_mul #(
    parameter int DATA_WIDTH = talu_pkg::DEF_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  talu_pkg::t_mul_ctl    i_ctl,
    input  logic [DATA_WIDTH-1:0] i_x,
    input  logic [DATA_WIDTH-1:0] i_y,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_p
);
    import talu_pkg::*;
    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] r_x, r_y, r_p;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DATA_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_p <= '0;
        end else if (r_busy) begin
            if (r_y[0]) r_p <= r_p + r_x;
            r_x <= r_x << 1;
            r_y <= r_y >> 1;
        end
    end

    assign o_done = r_done;
    assign o_p = r_p;
endmodule

// File: rtl/core/talu_div.sv
// Restoring divider on magnitudes, one quotient bit per cycle.
`timescale 1ns / 1ps
module talu_div #(
    parameter int DATA_WIDTH = talu_pkg::DEF_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_WIDTH-1:0] i_n,
    input  logic [DATA_WIDTH-1:0] i_d,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_q,
    output logic [DATA_WIDTH-1:0] o_r
);
    import talu_pkg::*;
    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] r_q, r_d, r_rm;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy, r_done;
    logic [DATA_WIDTH:0]   w_trial;

    assign w_trial = {r_rm, r_q[DATA_WIDTH-1]} - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DATA_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q  <= i_n;
            r_d  <= i_d;
            r_rm <= '0;
        end else if (r_busy) begin
            if (!w_trial[DATA_WIDTH]) begin
                r_rm <= w_trial[DATA_WIDTH-1:0];
                r_q  <= {r_q[DATA_WIDTH-2:0], 1'b1};
            end else begin
                r_rm <= {r_rm[DATA_WIDTH-2:0], r_q[DATA_WIDTH-1]};
                r_q  <= {r_q[DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_q = r_q;
    assign o_r = r_rm;
endmodule

// File: rtl/core/tagged_integer_alu.sv
// Top level of the tagged integer ALU: sequencer, serial multiplier and divider.
`timescale 1ns / 1ps
// One request at a time. Errors, a zero divisor, add, sub, min, max and bad opcodes
// finish in the EXEC state, as does pow with an exponent of at most one (result: base);
// mul runs on the bit-serial multiplier; div and rem on the restoring divider, one
// quotient bit per cycle; other pow runs square-and-multiply on the multiplier, a
// multiply and square on a set exponent bit, square only on a clear one, over all W bits.
// The result register holds until taken.
module tagged_integer_alu #(
    parameter int DATA_WIDTH = talu_pkg::DEF_DATA_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [3:0]                         i_cmd,
    input  logic                               i_a_is_err,
    input  logic [1:0]                         i_a_err_code,
    input  logic signed [talu_pkg::FIELD_WIDTH-1:0] i_a_value,
    input  logic                               i_b_is_err,
    input  logic [1:0]                         i_b_err_code,
    input  logic signed [talu_pkg::FIELD_WIDTH-1:0] i_b_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_res_is_err,
    output logic [1:0]                         o_res_err_code,
    output logic signed [talu_pkg::FIELD_WIDTH-1:0] o_res_value
);
    import talu_pkg::*;
    localparam int W = DATA_WIDTH;
    localparam int CW = $clog2(DATA_WIDTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_PMUL  = 3'd4;
    localparam logic [2:0] S_PSQ   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;
    localparam logic [2:0] S_PACC  = 3'd7;

    logic [2:0]   r_state;
    logic [3:0]   r_cmd;
    logic [W-1:0] r_x, r_y, r_acc, r_sq, r_e, r_res;
    logic [CW-1:0] r_ecnt;
    logic         r_err;
    logic [1:0]   r_code;
    logic         r_mstart, r_dstart;
    logic [W-1:0] r_mx, r_my;

    t_mul_ctl     w_mctl;
    logic         w_mdone, w_ddone;
    logic [W-1:0] w_p, w_q, w_rm, w_ux, w_uy;
    logic         w_sx, w_sy, w_ylt, w_yle1;
    logic         w_acc;
    logic         w_mul_go, w_div_go;

    assign w_sx = r_x[W-1];
    assign w_sy = r_y[W-1];
    assign w_ux = w_sx ? -r_x : r_x;
    assign w_uy = w_sy ? -r_y : r_y;
    assign w_ylt = $signed(r_x) <= $signed(r_y);
    assign w_yle1 = $signed(r_y) <= $signed(W'(1));
    assign w_mctl.start = r_mstart;
    assign w_acc = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);

    // multiplier launches: plain mul, each pow step, and the square after an acc update
    assign w_mul_go = (r_state == S_EXEC && !r_err && r_cmd == CMD_MUL)
                   || (r_state == S_PMUL && r_ecnt != '0)
                   || (r_state == S_PACC && w_mdone);
    assign w_div_go = r_state == S_EXEC && !r_err
                   && (r_cmd == CMD_DIV || r_cmd == CMD_REM) && r_y != '0;

    talu_mul #(.DATA_WIDTH(W)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_mctl),
        .i_x(r_mx), .i_y(r_my), .o_done(w_mdone), .o_p(w_p)
    );

    talu_div #(.DATA_WIDTH(W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_n(w_ux), .i_d(w_uy), .o_done(w_ddone), .o_q(w_q), .o_r(w_rm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mstart <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            r_mstart <= w_mul_go;
            r_dstart <= w_div_go;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_state <= S_EXEC;
                        r_cmd   <= i_cmd;
                        r_x     <= i_a_value[W-1:0];
                        r_y     <= i_b_value[W-1:0];
                        r_err   <= i_a_is_err | i_b_is_err;
                        r_code  <= i_a_is_err ? i_a_err_code : i_b_err_code;
                    end
                end
                S_EXEC: begin
                    if (r_err) begin
                        r_state <= S_OUT;
                    end else begin
                        unique case (r_cmd)
                            CMD_ADD: begin
                                r_res   <= r_x + r_y;
                                r_state <= S_OUT;
                            end
                            CMD_SUB: begin
                                r_res   <= r_x - r_y;
                                r_state <= S_OUT;
                            end
                            CMD_MUL: begin
                                r_mx <= r_x; r_my <= r_y;
                                r_state <= S_MUL;
                            end
                            CMD_DIV, CMD_REM: begin
                                if (r_y == '0) begin
                                    r_err   <= 1'b1;
                                    r_code  <= ERR_DIV_ZERO;
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_DIV;
                                end
                            end
                            CMD_POW: begin
                                if (w_yle1) begin
                                    r_res   <= r_x;
                                    r_state <= S_OUT;
                                end else begin
                                    r_acc  <= W'(1);
                                    r_sq   <= r_x;
                                    r_e    <= r_y;
                                    r_ecnt <= CW'(W);
                                    r_state <= S_PMUL;
                                end
                            end
                            CMD_MIN: begin
                                r_res   <= w_ylt ? r_x : r_y;
                                r_state <= S_OUT;
                            end
                            CMD_MAX: begin
                                r_res   <= w_ylt ? r_y : r_x;
                                r_state <= S_OUT;
                            end
                            default: begin
                                r_err   <= 1'b1;
                                r_code  <= ERR_BAD_OP;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    if (w_mdone) begin
                        r_res   <= w_p;
                        r_state <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (w_ddone) begin
                        if (r_cmd == CMD_DIV) r_res <= (w_sx ^ w_sy) ? -w_q : w_q;
                        else                  r_res <= w_sx ? -w_rm : w_rm;
                        r_state <= S_OUT;
                    end
                end
                // S_PMUL: end when no bits left; set bit: acc*sq, else square only
                S_PMUL: begin
                    if (r_ecnt == '0) begin
                        r_res   <= r_acc;
                        r_state <= S_OUT;
                    end else if (r_e[0]) begin
                        r_mx <= r_acc; r_my <= r_sq;
                        r_state <= S_PACC;
                    end else begin
                        r_mx <= r_sq; r_my <= r_sq;
                        r_state <= S_PSQ;
                    end
                end
                S_PACC: begin
                    if (w_mdone) begin
                        r_acc <= w_p;
                        r_mx  <= r_sq; r_my <= r_sq;
                        r_state <= S_PSQ;
                    end
                end
                S_PSQ: begin
                    if (w_mdone) begin
                        r_sq   <= w_p;
                        r_e    <= r_e >> 1;
                        r_ecnt <= r_ecnt - 1'b1;
                        r_state <= S_PMUL;
                    end
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = (r_state == S_OUT);
    assign o_res_is_err = r_err;
    assign o_res_err_code = r_err ? r_code : 2'd0;
    assign o_res_value = r_err ? '0
                       : {{(FIELD_WIDTH-W){r_res[W-1]}}, r_res};
endmodule

// File: rtl/core/talu_checker.sv
// Port-level checker for the tagged integer ALU, bound to the top level.
`timescale 1ns / 1ps
module talu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_res_is_err,
    input logic [1:0]  o_res_err_code,
    input logic [63:0] o_res_value
);
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result pending");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("ready right after accept");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res_value))
        else $error("result dropped");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res_is_err |-> o_res_value == 64'd0) else $error("error value");
    a_num_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res_is_err |-> o_res_err_code == 2'd0) else $error("code");
endmodule

bind tagged_integer_alu talu_checker u_talu_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_res_is_err(o_res_is_err),
    .o_res_err_code(o_res_err_code), .o_res_value(o_res_value)
);

// File: bench/tb_top.sv
// Testbench for the tagged integer ALU: random and directed requests against a built-in predictor.
`timescale 1ns / 1ps
module tb_top;
    import talu_pkg::*;

    localparam int W = DEF_DATA_WIDTH;
    localparam logic [1:0] ERR_BAD_NUM = 2'd2;
    localparam logic [1:0] ERR_UNUSED = 2'd3;
    localparam longint MAX_CYCLES = 3_000_000;
    localparam int HOLD_CYCLES = 600;

    typedef struct packed {
        logic        is_err;
        logic [1:0]  code;
        logic [63:0] value;
    } alu_res_t;

    class alu_scoreboard;
        alu_res_t pending[$];
        int       mismatches;
        int       checked;

        function logic [63:0] sx(logic [63:0] v);
            logic [63:0] m;
            m = (W == 64) ? '1 : ((64'd1 << W) - 1);
            v = v & m;
            if (v[W-1]) v = v | ~m;
            return v;
        endfunction

        function logic [63:0] ipow(logic [63:0] base, logic [63:0] e);
            logic [63:0] acc;
            acc = 64'd1;
            while (e != 0) begin
                if (e[0]) acc = acc * base;
                base = base * base;
                e = e >> 1;
            end
            return acc;
        endfunction

        function void note_request(logic [3:0] cmd, logic ae, logic [1:0] ac, logic [63:0] av,
                                   logic be, logic [1:0] bc, logic [63:0] bv);
            alu_res_t    r;
            logic signed [63:0] x, y;
            logic [63:0] ux, uy;
            r = '0;
            x = sx(av);
            y = sx(bv);
            if (ae) begin
                r.is_err = 1'b1; r.code = ac;
            end else if (be) begin
                r.is_err = 1'b1; r.code = bc;
            end else begin
                case (cmd)
                    CMD_ADD: r.value = x + y;
                    CMD_SUB: r.value = x - y;
                    CMD_MUL: r.value = x * y;
                    CMD_DIV, CMD_REM: begin
                        if (y == 0) begin
                            r.is_err = 1'b1; r.code = ERR_DIV_ZERO;
                        end else begin
                            ux = x[63] ? -x : x;
                            uy = y[63] ? -y : y;
                            if (cmd == CMD_DIV)
                                r.value = (x[63] ^ y[63]) ? -(ux / uy) : ux / uy;
                            else
                                r.value = x[63] ? -(ux % uy) : ux % uy;
                        end
                    end
                    CMD_POW: r.value = (y <= 1) ? x : ipow(x, y);
                    CMD_MIN: r.value = (x <= y) ? x : y;
                    CMD_MAX: r.value = (y <= x) ? x : y;
                    default: begin
                        r.is_err = 1'b1; r.code = ERR_BAD_OP;
                    end
                endcase
            end
            if (!r.is_err) r.value = sx(r.value);
            pending.push_back(r);
        endfunction

        function void check_result(logic ie, logic [1:0] c, logic [63:0] v);
            alu_res_t e;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result err=%0b code=%0d val=%h", ie, c, v);
                return;
            end
            e = pending.pop_front();
            if (e.is_err !== ie || e.code !== c || e.value !== v) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp err=%0b code=%0d val=%h got err=%0b code=%0d val=%h",
                             e.is_err, e.code, e.value, ie, c, v);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [3:0]  cmd = '0;
    logic        a_err = 1'b0, b_err = 1'b0;
    logic [1:0]  a_code = '0, b_code = '0;
    logic signed [63:0] a_val = '0, b_val = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        res_err;
    logic [1:0]  res_code;
    logic signed [63:0] res_val;

    alu_scoreboard sb;
    int  send_idle_pct = 0;
    int  stall_pct = 0;
    int  hold_reqs = 0;
    int  hold_seen = 0;
    int  hold_off = 0;
    longint cycles = 0;

    always #6 clk = ~clk;

    tagged_integer_alu u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_cmd(cmd), .i_a_is_err(a_err), .i_a_err_code(a_code), .i_a_value(a_val),
        .i_b_is_err(b_err), .i_b_err_code(b_code), .i_b_value(b_val),
        .o_valid(out_valid), .i_ready(out_ready), .o_res_is_err(res_err),
        .o_res_err_code(res_code), .o_res_value(res_val)
    );

    // receiver: random stalls, plus a long hold-off when requested
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(res_err, res_code, res_val);
        if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_off <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top: errors");
            $finish;
        end
    end

    // valid stays up after an accept only until this same step hands over the next request
    task automatic send_request(logic [3:0] c, logic ae, logic [1:0] ac, logic [63:0] av,
                                logic be, logic [1:0] bc, logic [63:0] bv);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        cmd <= c; a_err <= ae; a_code <= ac; a_val <= av;
        b_err <= be; b_code <= bc; b_val <= bv;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_request(c, ae, ac, av, be, bc, bv);
    endtask

    function automatic logic [63:0] pick_value(bit short);
        case ($urandom_range(7))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return 64'($signed($urandom_range(6)) - 3);
            3, 4: return short ? 64'($signed($urandom_range(40)) - 20)
                               : {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_random();
        logic [3:0]  c;
        logic        ae, be;
        logic [63:0] av, bv;
        c = ($urandom_range(9) == 0) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(7));
        ae = ($urandom_range(9) == 0);
        be = ($urandom_range(9) == 0);
        av = pick_value(0);
        bv = pick_value(c == CMD_POW || c == CMD_DIV || c == CMD_REM);
        if (c == CMD_POW && $urandom_range(3) == 0) bv = {$urandom, $urandom};
        send_request(c, ae, 2'($urandom), av, be, 2'($urandom), bv);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial begin
        logic [63:0] mn, mx, m1;
        sb = new();
        mn = 64'h8000_0000_0000_0000;
        mx = 64'h7fff_ffff_ffff_ffff;
        m1 = '1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        send_request(CMD_ADD, 0, 0, mx, 0, 0, 64'd1);
        send_request(CMD_SUB, 0, 0, mn, 0, 0, 64'd1);
        send_request(CMD_MUL, 0, 0, mx, 0, 0, mx);
        send_request(CMD_DIV, 0, 0, mn, 0, 0, m1);
        send_request(CMD_REM, 0, 0, mn, 0, 0, m1);
        send_request(CMD_DIV, 0, 0, 64'd7, 0, 0, 64'd0);
        send_request(CMD_REM, 0, 0, mn, 0, 0, 64'd0);
        send_request(CMD_REM, 0, 0, -64'sd7, 0, 0, 64'd2);
        send_request(CMD_DIV, 0, 0, -64'sd7, 0, 0, 64'd2);
        send_request(CMD_POW, 0, 0, 64'd3, 0, 0, 64'd1);
        send_request(CMD_POW, 0, 0, 64'd3, 0, 0, mn);
        send_request(CMD_POW, 0, 0, -64'sd3, 0, 0, 64'd5);
        send_request(CMD_POW, 0, 0, 64'd3, 0, 0, mx);
        send_request(CMD_MIN, 0, 0, mn, 0, 0, mx);
        send_request(CMD_MAX, 0, 0, mn, 0, 0, mx);
        send_request(CMD_MIN, 0, 0, 64'd5, 0, 0, 64'd5);
        send_request(4'd8, 0, 0, 64'd1, 0, 0, 64'd1);
        send_request(4'd15, 0, 0, mx, 0, 0, mn);
        send_request(CMD_ADD, 1, ERR_BAD_NUM, mx, 1, ERR_BAD_OP, mn);
        send_request(CMD_DIV, 0, 0, 64'd1, 1, ERR_UNUSED, 64'd0);
        send_request(4'd9, 1, ERR_UNUSED, m1, 0, 0, m1);
        send_request(CMD_MUL, 0, 0, m1, 1, ERR_DIV_ZERO, m1);
        drain();

        // random phases with different idle mixes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 69; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 69; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            for (int i = 0; i < 170; i++) send_random();
            drain();
        end

        // long receiver hold-off while requests keep coming
        send_idle_pct = 0;
        stall_pct = 0;
        hold_reqs = hold_reqs + 1;
        for (int i = 0; i < 10; i++) send_random();
        drain();

        $display("covered %0d results over all opcodes, error passthrough and idle mixes",
                 sb.checked);
        if (sb.mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule

// File: files.f
rtl/core/talu_pkg.sv
rtl/core/talu_mul.sv
rtl/core/talu_div.sv
rtl/core/tagged_integer_alu.sv
rtl/core/talu_checker.sv
bench/tb_top.sv
